>>> src/wgmn_pkg.sv
// Shared constants, command/status structs and helpers for the weighted group max norm core.
package wgmn_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W + 1;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int WEIGHT_W   = 16;
  localparam int ROOT_W     = SAMPLE_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int REM_W      = ROOT_W + 3;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = WEIGHT_W + SQ_W;
  localparam int IN_DATA_W  = 3 * SAMPLE_W;
  localparam int OUT_DATA_W = ACC_W;

  typedef struct packed {
    logic load;
    logic square;
    logic max_upd;
    logic root_init;
    logic root_step;
    logic scale;
    logic accum;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cplx;
    logic eog;
    logic eon;
    logic out_free;
  } dp_stat_t;

  function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[SAMPLE_W-1], v};
    return v[SAMPLE_W-1] ? (~ext + 1'b1) : ext;
  endfunction

endpackage

>>> src/weighted_group_max_norm_core.sv
// Top level of the weighted group max norm core: controller plus datapath.
//
//  channel  | ports                                   | beat contents
//  ---------+-----------------------------------------+------------------------------------
//  in       | in_tvalid/in_tready/in_tdata/tlast/tuser | real, imag, weight; tlast=end_of_group,
//           |                                         | tuser=end_of_norm
//  out      | out_tvalid/out_tready/out_tdata/tuser   | norm_value; tuser=saturated
//  cfg      | cfg_valid/cfg_ready/cfg_data            | complex_mode
//
// One input beat at a time: an inner coefficient passes load, square and max update; a group
// close adds scaling and accumulation, in complex mode after the 16-step square root unit;
// when the norm ends, the output register is loaded once it is free.
// Reset is synchronous, active low, and clears the mode, the running max and the sum.
// The output register holds a result while out_tready is low; the block keeps taking
// beats until it must load a new result into a still occupied output register.
module weighted_group_max_norm_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wgmn_pkg::IN_DATA_W-1:0]      in_tdata,  // [15:0] real_part, [31:16] imag_part,
                                                         // [47:32] weight
  input  logic                                in_tlast,
  input  logic                                in_tuser,  // [0] end_of_norm
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wgmn_pkg::OUT_DATA_W-1:0]     out_tdata, // [47:0] norm_value
  output logic                                out_tuser, // [0] saturated
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data
);

  wgmn_pkg::dp_cmd_t  cmd;
  wgmn_pkg::dp_stat_t stat;
  logic               in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = in_tvalid && in_tready;

  wgmn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_tready)
  );

  wgmn_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_tdata),
    .in_eog    (in_tlast),
    .in_eon    (in_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_bit   (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_sat   (out_tuser)
  );

endmodule

>>> src/wgmn_ctrl.sv
// Controller state machine sequencing one beat through the datapath.
module wgmn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  wgmn_pkg::dp_stat_t  stat,
  output wgmn_pkg::dp_cmd_t   cmd,
  output logic                in_ready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MAXUP,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_SCALE,
    ST_ACCUM,
    ST_FINISH
  } state_t;

  state_t                       state_r;
  state_t                       state_nxt;
  logic [wgmn_pkg::STEP_W-1:0]  step_r;
  logic [wgmn_pkg::STEP_W-1:0]  step_nxt;
  logic                         root_last;

  assign root_last = (step_r == wgmn_pkg::STEP_W'(wgmn_pkg::ROOT_STEPS - 1));
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_MAXUP;
      end
      ST_MAXUP: begin
        cmd.max_upd = 1'b1;
        priority if (stat.eog && stat.cplx) state_nxt = ST_ROOT_INIT;
        else if (stat.eog)                  state_nxt = ST_SCALE;
        else if (stat.eon)                  state_nxt = ST_FINISH;
        else                                state_nxt = ST_IDLE;
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (root_last) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = stat.eon ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

>>> src/wgmn_dp.sv
// Datapath: magnitude, running maximum, iterative square root, weighting and accumulation.
module wgmn_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wgmn_pkg::dp_cmd_t                   cmd,
  output wgmn_pkg::dp_stat_t                  stat,
  input  logic [wgmn_pkg::IN_DATA_W-1:0]      in_data,
  input  logic                                in_eog,
  input  logic                                in_eon,
  input  logic                                cfg_we,
  input  logic                                cfg_bit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wgmn_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_sat
);

  localparam int SW = wgmn_pkg::SAMPLE_W;

  logic                              cplx_r;
  logic                              eog_r;
  logic                              eon_r;
  logic [wgmn_pkg::MAG_W-1:0]        mag_a_r;
  logic [wgmn_pkg::MAG_W-1:0]        mag_b_r;
  logic [wgmn_pkg::WEIGHT_W-1:0]     weight_r;
  logic [wgmn_pkg::SQ_W-1:0]         sq_a_r;
  logic [wgmn_pkg::SQ_W-1:0]         sq_b_r;
  logic [wgmn_pkg::SQ_W-1:0]         group_max_r;
  logic [wgmn_pkg::SQ_W-1:0]         mag_now;
  logic [wgmn_pkg::SQ_W-1:0]         rad_r;
  logic [wgmn_pkg::REM_W-1:0]        rem_r;
  logic [wgmn_pkg::ROOT_W-1:0]       root_r;
  logic [wgmn_pkg::REM_W-1:0]        rem_sh;
  logic [wgmn_pkg::REM_W-1:0]        trial;
  logic [wgmn_pkg::SQ_W-1:0]         gm;
  logic [wgmn_pkg::PROD_W-1:0]       prod_r;
  logic [wgmn_pkg::ACC_W-1:0]        norm_sum_r;
  logic                              ovf_r;
  logic [wgmn_pkg::ACC_W:0]          sum_ext;
  logic                              out_valid_r;
  logic [wgmn_pkg::OUT_DATA_W-1:0]   out_data_r;
  logic                              out_sat_r;

  assign stat.cplx     = cplx_r;
  assign stat.eog      = eog_r;
  assign stat.eon      = eon_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_sat   = out_sat_r;

  assign mag_now = cplx_r ? (sq_a_r + sq_b_r) : wgmn_pkg::SQ_W'(mag_a_r);
  assign rem_sh  = {rem_r[wgmn_pkg::REM_W-3:0], rad_r[wgmn_pkg::SQ_W-1 -: 2]};
  assign trial   = wgmn_pkg::REM_W'({root_r, 2'b01});
  assign gm      = cplx_r ? wgmn_pkg::SQ_W'(root_r) : group_max_r;
  assign sum_ext = {1'b0, norm_sum_r} + (wgmn_pkg::ACC_W + 1)'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cplx_r <= 1'b0;
    end else if (cfg_we) begin
      cplx_r <= cfg_bit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_a_r  <= wgmn_pkg::magnitude(in_data[SW-1:0]);
      mag_b_r  <= wgmn_pkg::magnitude(in_data[2*SW-1:SW]);
      weight_r <= in_data[3*SW-1:2*SW];
      eog_r    <= in_eog;
      eon_r    <= in_eon;
    end
    if (cmd.square) begin
      sq_a_r <= wgmn_pkg::SQ_W'(mag_a_r) * wgmn_pkg::SQ_W'(mag_a_r);
      sq_b_r <= wgmn_pkg::SQ_W'(mag_b_r) * wgmn_pkg::SQ_W'(mag_b_r);
    end
    if (cmd.root_init) begin
      rad_r  <= group_max_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[wgmn_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[wgmn_pkg::ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.scale) begin
      prod_r <= wgmn_pkg::PROD_W'(weight_r) * wgmn_pkg::PROD_W'(gm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_max_r <= '0;
      norm_sum_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.max_upd && (mag_now > group_max_r)) group_max_r <= mag_now;
      if (cmd.accum) begin
        group_max_r <= '0;
        if (sum_ext[wgmn_pkg::ACC_W]) begin
          norm_sum_r <= '1;
          ovf_r      <= 1'b1;
        end else begin
          norm_sum_r <= sum_ext[wgmn_pkg::ACC_W-1:0];
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        group_max_r <= '0;
        norm_sum_r  <= '0;
        ovf_r       <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= norm_sum_r;
      out_sat_r  <= ovf_r;
    end
  end

endmodule

>>> src/wgmn_checker.sv
// Port-level checker for the weighted group max norm core, bound to the top level.
module wgmn_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wgmn_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tuser
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one beat in flight
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a beat is in flight");

  // inner coefficient returns to idle after square and max update
  a_inner_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !in_tuser |-> ##3 in_tready)
    else $error("inner coefficient did not finish in three cycles");

  // drop result valid on reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind weighted_group_max_norm_core wgmn_checker u_wgmn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> bench/tb_weighted_group_max_norm_core.sv
// Self-checking bench for the weighted group max norm core: directed, stalled, random.
`timescale 1ns / 1ps

module tb_weighted_group_max_norm_core;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 200;
  localparam logic [63:0] ACC_MAX = (64'd1 << wgmn_pkg::ACC_W) - 64'd1;

  typedef struct packed {
    logic [wgmn_pkg::ACC_W-1:0] value;
    logic                       sat;
  } norm_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [wgmn_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // [15:0] real_part, [31:16] imag_part,
                                                    // [47:32] weight
  logic                            in_tlast = 1'b0;
  logic                            in_tuser = 1'b0; // [0] end_of_norm
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [wgmn_pkg::OUT_DATA_W-1:0] out_tdata;       // [47:0] norm_value
  logic                            out_tuser;       // [0] saturated
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_data = 1'b0;

  logic                  in_gaps = 1'b1;
  logic                  out_gaps = 1'b1;
  logic                  rx_hold = 1'b0;
  int                    rx_gap = 0;
  int                    errors = 0;

  logic                  mode_q = 1'b0;
  logic [31:0]           run_max = '0;
  logic [63:0]           norm_acc = '0;
  logic                  norm_sat = 1'b0;
  norm_t                 norms_pending[$];

  weighted_group_max_norm_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] abs_sample(input logic [wgmn_pkg::SAMPLE_W-1:0] v);
    logic signed [wgmn_pkg::SAMPLE_W:0] x;
    x = $signed({v[wgmn_pkg::SAMPLE_W-1], v});
    if (x < 0) x = -x;
    return {{(64-wgmn_pkg::SAMPLE_W-1){1'b0}}, x};
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = 16; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Fold one accepted beat into the running norm; queue the total on end of norm.
  task automatic fold_coef(input logic [wgmn_pkg::SAMPLE_W-1:0] re,
                           input logic [wgmn_pkg::SAMPLE_W-1:0] im,
                           input logic [wgmn_pkg::WEIGHT_W-1:0] w,
                           input logic eog, input logic eon);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] g;
    logic [63:0] prod;
    norm_t       n;
    a = abs_sample(re);
    b = abs_sample(im);
    m = mode_q ? (a * a + b * b) : a;
    if (m > {32'd0, run_max}) run_max = m[31:0];
    if (eog) begin
      g = mode_q ? floor_root({32'd0, run_max}) : {32'd0, run_max};
      prod = {48'd0, w} * g;
      if (prod > ACC_MAX - norm_acc) begin
        norm_acc = ACC_MAX;
        norm_sat = 1'b1;
      end else begin
        norm_acc = norm_acc + prod;
      end
      run_max = '0;
    end
    if (eon) begin
      n.value = norm_acc[wgmn_pkg::ACC_W-1:0];
      n.sat = norm_sat;
      norms_pending.push_back(n);
      run_max = '0;
      norm_acc = '0;
      norm_sat = 1'b0;
    end
  endtask

  task automatic check_norm(input logic [wgmn_pkg::ACC_W-1:0] v, input logic s);
    norm_t e;
    if (norms_pending.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual value %h sat %b", $time, v, s);
      errors++;
    end else begin
      e = norms_pending.pop_front();
      if (e.value !== v) begin
        $display("%0t: norm_value expected %h actual %h", $time, e.value, v);
        errors++;
      end
      if (e.sat !== s) begin
        $display("%0t: saturated expected %b actual %b", $time, e.sat, s);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) check_norm(out_tdata[wgmn_pkg::ACC_W-1:0], out_tuser);
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_tready <= 1'b0;
      end else if (out_gaps && $urandom_range(0, 4) == 0) begin
        rx_gap <= $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= !rx_hold;
      end
    end
  end

  task automatic send_coef(input logic [wgmn_pkg::SAMPLE_W-1:0] re,
                           input logic [wgmn_pkg::SAMPLE_W-1:0] im,
                           input logic [wgmn_pkg::WEIGHT_W-1:0] w,
                           input logic eog, input logic eon);
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {w, im, re};
    in_tlast <= eog;
    in_tuser <= eon;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_coef(re, im, w, eog, eon);
  endtask

  // Drop valid, wait for every pending norm, then let the datapath settle.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (norms_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_q = m;
  endtask

  function automatic logic [wgmn_pkg::SAMPLE_W-1:0] rand_sample;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return wgmn_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [wgmn_pkg::WEIGHT_W-1:0] rand_weight;
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return wgmn_pkg::WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic test_real_extremes;
    set_mode(1'b0);
    send_coef(16'h7fff, 16'h8000, 16'hffff, 1'b0, 1'b0);
    send_coef(16'h8000, 16'h7fff, 16'hffff, 1'b1, 1'b0);
    send_coef(16'h7fff, 16'h0000, 16'hffff, 1'b1, 1'b0);
    send_coef(16'h0000, 16'hffff, 16'h0000, 1'b1, 1'b0);
    send_coef(16'hfffb, 16'h8000, 16'h0001, 1'b1, 1'b1);
  endtask

  task automatic test_complex_extremes;
    set_mode(1'b1);
    send_coef(16'h8000, 16'h8000, 16'hffff, 1'b1, 1'b0);
    send_coef(16'h7fff, 16'h0000, 16'h1234, 1'b1, 1'b0);
    send_coef(16'h0003, 16'hfffc, 16'h0001, 1'b0, 1'b0);
    send_coef(16'h0000, 16'h0000, 16'h0002, 1'b1, 1'b0);
    send_coef(16'h0000, 16'h0000, 16'hffff, 1'b1, 1'b1);
  endtask

  task automatic test_open_group_at_norm_end;
    set_mode(1'b0);
    send_coef(16'h0064, 16'h0000, 16'h0003, 1'b1, 1'b0);
    send_coef(16'h7fff, 16'h0000, 16'hffff, 1'b0, 1'b0);
    send_coef(16'h00c8, 16'h0000, 16'hffff, 1'b0, 1'b1);
  endtask

  task automatic test_mode_switch_in_group;
    set_mode(1'b0);
    send_coef(16'h7530, 16'h0000, 16'h0000, 1'b0, 1'b0);
    set_mode(1'b1);
    send_coef(16'h0001, 16'h0001, 16'h0002, 1'b1, 1'b1);
    send_coef(16'h0005, 16'h000c, 16'h0000, 1'b0, 1'b0);
    set_mode(1'b0);
    send_coef(16'h0002, 16'h0000, 16'h0003, 1'b1, 1'b1);
  endtask

  // Carry a full-scale squared modulus into real mode so each close adds about 2^47.
  task automatic test_saturation;
    for (int i = 0; i < 3; i++) begin
      set_mode(1'b1);
      send_coef(16'h8000, 16'h8000, 16'h0000, 1'b0, 1'b0);
      set_mode(1'b0);
      send_coef(16'h0000, 16'h0000, 16'hffff, 1'b1, i == 2);
    end
  endtask

  task automatic test_output_backpressure;
    set_mode(1'b0);
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 10; i++) send_coef(rand_sample(), rand_sample(), rand_weight(), 1'b1, 1'b1);
    drain();
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  task automatic test_random_stream(input int n_items, input logic gaps);
    int sent;
    int grp_len;
    logic eog;
    logic eon;
    in_gaps = gaps;
    out_gaps = gaps;
    sent = 0;
    while (sent < n_items) begin
      grp_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (int k = 0; k < grp_len; k++) begin
        if (k > 0 && $urandom_range(0, 39) == 0) set_mode(!mode_q);
        eog = (k == grp_len - 1);
        eon = eog ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 63) == 0);
        send_coef(rand_sample(), rand_sample(), rand_weight(), eog, eon);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_real_extremes();
    test_complex_extremes();
    test_open_group_at_norm_end();
    test_mode_switch_in_group();
    test_saturation();
    test_output_backpressure();
    for (int p = 0; p < 7; p++) begin
      set_mode((p < 2) ? p[0] : 1'($urandom_range(0, 1)));
      test_random_stream(200, 1'b1);
    end
    set_mode(1'($urandom_range(0, 1)));
    test_random_stream(200, 1'b0);
    drain();
    if (errors == 0) begin
      $display("PASS weighted_group_max_norm_core");
    end else begin
      $display("FAIL weighted_group_max_norm_core");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL weighted_group_max_norm_core");
    $finish;
  end

endmodule

>>> weighted_group_max_norm_core.f
src/wgmn_pkg.sv
src/wgmn_ctrl.sv
src/wgmn_dp.sv
src/weighted_group_max_norm_core.sv
src/wgmn_checker.sv
bench/tb_weighted_group_max_norm_core.sv
